@@ design/assert_macros.svh @@
// Assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/c8x_pkg.sv @@
// Shared types, constants and codes of the CHIP-8 executor
package c8x_pkg;

   localparam int MemDepthDefault   = 4096;
   localparam int StackDepthDefault = 16;

   localparam logic [11:0] PC_RESET = 12'd512;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_OVER  = 2'd1;
   localparam logic [1:0] ST_UNDER = 2'd2;
   localparam logic [1:0] ST_UNSUP = 2'd3;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_DECODE,
      CTL_MEMRD,
      CTL_MEMWAIT,
      CTL_BLOCK,
      CTL_BCD,
      CTL_DONE
   } ctl_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the request
      logic exec;      // execute an ordinary opcode or a load
      logic blk_start; // clear block and BCD counters
      logic blk_step;  // process one byte of a block op
      logic bcd_step;  // write one BCD digit
      logic rd_issue;  // issue a memory read
      logic out_load;  // load the result register
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_store_blk;
      logic is_load_blk;
      logic is_bcd;
      logic blk_last;
      logic bcd_last;
   } dp_sts_type;

endpackage

@@ design/c8x_ctrl.sv @@
// Controller state machine of the CHIP-8 executor
module c8x_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  c8x_pkg::dp_sts_type sts,
   output c8x_pkg::dp_cmd_type cmd
);
   import c8x_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   // Requests are taken only in idle; the result register is refilled once the previous one is taken
   assign req_ready = (state_ff == CTL_IDLE);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         CTL_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = CTL_DECODE;
            end
         end
         CTL_DECODE: begin
            if (sts.is_store_blk || sts.is_load_blk) begin
               cmd.blk_start = 1'b1;
               state_in      = CTL_MEMRD;
            end else if (sts.is_bcd) begin
               cmd.blk_start = 1'b1;
               state_in      = CTL_BCD;
            end else begin
               cmd.exec = 1'b1;
               state_in = CTL_DONE;
            end
         end
         CTL_MEMRD: begin
            if (sts.is_load_blk) begin
               cmd.rd_issue = 1'b1;
               state_in     = CTL_MEMWAIT;
            end else begin
               state_in = CTL_BLOCK;
            end
         end
         CTL_MEMWAIT: state_in = CTL_BLOCK;
         CTL_BLOCK: begin
            cmd.blk_step = 1'b1;
            state_in     = sts.blk_last ? CTL_DONE : CTL_MEMRD;
         end
         CTL_BCD: begin
            cmd.bcd_step = 1'b1;
            if (sts.bcd_last) state_in = CTL_DONE;
         end
         CTL_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = CTL_IDLE;
            end
         end
         default: state_in = CTL_IDLE;
      endcase
   end
endmodule

@@ design/c8x_dpath.sv @@
// Datapath of the CHIP-8 executor: registers, stack, memory and result
module c8x_dpath #(
   parameter int MEM_DEPTH   = c8x_pkg::MemDepthDefault,
   parameter int STACK_DEPTH = c8x_pkg::StackDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  c8x_pkg::dp_cmd_type cmd,
   output c8x_pkg::dp_sts_type sts,
   input  logic                req_type,
   input  logic [15:0]         req_opcode,
   input  logic [15:0]         req_key_mask,
   input  logic [7:0]          req_random_byte,
   input  logic [11:0]         req_load_addr,
   input  logic [7:0]          req_load_data,
   output logic [11:0]         rsp_next_pc,
   output logic [15:0]         rsp_index_value,
   output logic [7:0]          rsp_flag_value,
   output logic [7:0]          rsp_delay_value,
   output logic [7:0]          rsp_sound_value,
   output logic [1:0]          rsp_status
);
   import c8x_pkg::*;

   localparam int AW = $clog2(MEM_DEPTH);
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int LW = $clog2(STACK_DEPTH + 1);

   // request latches
   logic        type_ff;
   logic [15:0] op_ff, keys_ff;
   logic [7:0]  rnd_ff, ldata_ff;
   logic [11:0] laddr_ff;

   // architectural state
   logic [7:0]  vreg_ff [16];
   logic [15:0] idx_ff;
   logic [11:0] pc_ff;
   logic [LW-1:0] sp_ff;
   logic [7:0]  dt_ff, st_ff;
   logic [1:0]  status_ff;
   logic [11:0] stack_mem [STACK_DEPTH];
   logic [7:0]  main_mem [MEM_DEPTH];
   logic [7:0]  rd_data_ff;
   logic [3:0]  cnt_ff;
   logic [1:0]  bcd_ff;
   logic [7:0]  bcd_val_ff;

   logic [11:0] out_pc_ff;
   logic [15:0] out_idx_ff;
   logic [7:0]  out_vf_ff, out_dt_ff, out_st_ff;
   logic [1:0]  out_status_ff;

   logic [3:0]  x, y, n;
   logic [7:0]  nn, vx, vy;
   logic [11:0] nnn, pc2, pc4;
   logic [15:0] blk_addr;
   logic [15:0] idx_k;

   assign x   = op_ff[11:8];
   assign y   = op_ff[7:4];
   assign n   = op_ff[3:0];
   assign nn  = op_ff[7:0];
   assign nnn = op_ff[11:0];
   assign vx  = vreg_ff[x];
   assign vy  = vreg_ff[y];
   assign pc2 = pc_ff + 12'd2;
   assign pc4 = pc_ff + 12'd4;
   assign idx_k    = idx_ff + {12'd0, cnt_ff};
   assign blk_addr = idx_k;

   assign sts.is_store_blk = !type_ff && op_ff[15:12] == 4'hF && nn == 8'h55;
   assign sts.is_load_blk  = !type_ff && op_ff[15:12] == 4'hF && nn == 8'h65;
   assign sts.is_bcd       = !type_ff && op_ff[15:12] == 4'hF && nn == 8'h33;
   assign sts.blk_last     = (cnt_ff == x);
   assign sts.bcd_last     = (bcd_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff  <= req_type;
         op_ff    <= req_opcode;
         keys_ff  <= req_key_mask;
         rnd_ff   <= req_random_byte;
         laddr_ff <= req_load_addr;
         ldata_ff <= req_load_data;
      end
   end

   // BCD digits: hundreds by compare and subtract, tens by reciprocal multiply
   logic [1:0]  bcd_hund;
   logic [7:0]  bcd_rem100, bcd_rem10;
   logic [15:0] bcd_prod;
   logic [3:0]  bcd_tens;

   always_comb begin
      if (bcd_val_ff >= 8'd200) begin
         bcd_hund   = 2'd2;
         bcd_rem100 = bcd_val_ff - 8'd200;
      end else if (bcd_val_ff >= 8'd100) begin
         bcd_hund   = 2'd1;
         bcd_rem100 = bcd_val_ff - 8'd100;
      end else begin
         bcd_hund   = 2'd0;
         bcd_rem100 = bcd_val_ff;
      end
   end

   assign bcd_prod  = {8'd0, bcd_val_ff} * 16'd205;
   assign bcd_tens  = bcd_prod[14:11];
   assign bcd_rem10 = bcd_val_ff - {1'b0, bcd_tens, 3'b000} - {3'b000, bcd_tens, 1'b0};

   // memory: one write port, one registered read port
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = blk_addr[AW-1:0];
      mem_wdata = vreg_ff[cnt_ff];
      if (cmd.exec && type_ff) begin
         mem_we    = 1'b1;
         mem_waddr = AW'(laddr_ff);
         mem_wdata = ldata_ff;
      end else if (cmd.blk_step && sts.is_store_blk) begin
         mem_we = 1'b1;
      end else if (cmd.bcd_step) begin
         mem_we    = 1'b1;
         mem_waddr = AW'(idx_ff + {14'd0, bcd_ff});
         case (bcd_ff)
            2'd0:    mem_wdata = {6'd0, bcd_hund};
            2'd1:    mem_wdata = {4'd0, bcd_tens};
            default: mem_wdata = bcd_val_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) main_mem[mem_waddr] <= mem_wdata;
      if (cmd.rd_issue) rd_data_ff <= main_mem[blk_addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.blk_start) begin
         cnt_ff     <= '0;
         bcd_ff     <= '0;
         bcd_val_ff <= vx;
      end else begin
         if (cmd.blk_step) cnt_ff <= cnt_ff + 4'd1;
         if (cmd.bcd_step) begin
            bcd_ff <= bcd_ff + 2'd1;
            // keep the remainder for the next digit
            case (bcd_ff)
               2'd0:    bcd_val_ff <= bcd_rem100;
               2'd1:    bcd_val_ff <= bcd_rem10;
               default: bcd_val_ff <= bcd_val_ff;
            endcase
         end
      end
   end

   logic pressed;
   assign pressed = (vx[7:4] == 4'd0) && keys_ff[vx[3:0]];

   logic [8:0] sum9;
   logic [8:0] sub_xy, sub_yx;
   assign sum9   = {1'b0, vx} + {1'b0, vy};
   assign sub_xy = {1'b0, vx} - {1'b0, vy};
   assign sub_yx = {1'b0, vy} - {1'b0, vx};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) vreg_ff[i] <= '0;
         idx_ff    <= '0;
         pc_ff     <= PC_RESET;
         sp_ff     <= '0;
         dt_ff     <= '0;
         st_ff     <= '0;
         status_ff <= ST_OK;
      end else if (cmd.blk_start) begin
         status_ff <= ST_OK;
         pc_ff     <= pc2;
      end else if (cmd.blk_step) begin
         if (sts.is_load_blk) vreg_ff[cnt_ff] <= rd_data_ff;
      end else if (cmd.exec) begin
         status_ff <= ST_OK;
         if (!type_ff) begin
            pc_ff <= pc2;
            case (op_ff[15:12])
               4'h0: begin
                  if (op_ff == 16'h00EE) begin
                     if (sp_ff == '0) status_ff <= ST_UNDER;
                     else begin
                        sp_ff <= sp_ff - 1'b1;
                        pc_ff <= stack_mem[SW'(sp_ff - 1'b1)];
                     end
                  end else status_ff <= ST_UNSUP;
               end
               4'h1: pc_ff <= nnn;
               4'h2: begin
                  if (sp_ff == LW'(STACK_DEPTH)) status_ff <= ST_OVER;
                  else begin
                     stack_mem[SW'(sp_ff)] <= pc2;
                     sp_ff <= sp_ff + 1'b1;
                     pc_ff <= nnn;
                  end
               end
               4'h3: if (vx == nn) pc_ff <= pc4;
               4'h4: if (vx != nn) pc_ff <= pc4;
               4'h5: begin
                  if (n != 4'd0) status_ff <= ST_UNSUP;
                  else if (vx == vy) pc_ff <= pc4;
               end
               4'h6: vreg_ff[x] <= nn;
               4'h7: vreg_ff[x] <= vx + nn;
               4'h8: begin
                  // for the flag-setting ops with VF as target the flag is what lands
                  case (n)
                     4'h0: vreg_ff[x] <= vy;
                     4'h1: vreg_ff[x] <= vx | vy;
                     4'h2: vreg_ff[x] <= vx & vy;
                     4'h3: vreg_ff[x] <= vx ^ vy;
                     4'h4: begin
                        if (x != 4'hF) vreg_ff[x] <= sum9[7:0];
                        vreg_ff[15] <= {7'd0, sum9[8]};
                     end
                     4'h5: begin
                        if (x != 4'hF) vreg_ff[x] <= sub_xy[7:0];
                        vreg_ff[15] <= {7'd0, !sub_xy[8]};
                     end
                     4'h6: begin
                        if (x != 4'hF) vreg_ff[x] <= {1'b0, vx[7:1]};
                        vreg_ff[15] <= {7'd0, vx[0]};
                     end
                     4'h7: begin
                        if (x != 4'hF) vreg_ff[x] <= sub_yx[7:0];
                        vreg_ff[15] <= {7'd0, !sub_yx[8]};
                     end
                     4'hE: begin
                        if (x != 4'hF) vreg_ff[x] <= {vx[6:0], 1'b0};
                        vreg_ff[15] <= {7'd0, vx[7]};
                     end
                     default: status_ff <= ST_UNSUP;
                  endcase
               end
               4'h9: begin
                  if (n != 4'd0) status_ff <= ST_UNSUP;
                  else if (vx != vy) pc_ff <= pc4;
               end
               4'hA: idx_ff <= {4'd0, nnn};
               4'hB: pc_ff <= nnn + {4'd0, vreg_ff[0]};
               4'hC: vreg_ff[x] <= rnd_ff & nn;
               4'hE: begin
                  if (nn == 8'h9E) begin
                     if (pressed) pc_ff <= pc4;
                  end else if (nn == 8'hA1) begin
                     if (!pressed) pc_ff <= pc4;
                  end else status_ff <= ST_UNSUP;
               end
               4'hF: begin
                  case (nn)
                     8'h07: vreg_ff[x] <= dt_ff;
                     8'h15: dt_ff <= vx;
                     8'h18: st_ff <= vx;
                     8'h1E: idx_ff <= idx_ff + {8'd0, vx};
                     8'h29: idx_ff <= {6'd0, vx, 2'b00} + {8'd0, vx};
                     default: status_ff <= ST_UNSUP;
                  endcase
               end
               default: status_ff <= ST_UNSUP;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_pc_ff     <= pc_ff;
         out_idx_ff    <= idx_ff;
         out_vf_ff     <= vreg_ff[15];
         out_dt_ff     <= dt_ff;
         out_st_ff     <= st_ff;
         out_status_ff <= status_ff;
      end
   end

   assign rsp_next_pc     = out_pc_ff;
   assign rsp_index_value = out_idx_ff;
   assign rsp_flag_value  = out_vf_ff;
   assign rsp_delay_value = out_dt_ff;
   assign rsp_sound_value = out_st_ff;
   assign rsp_status      = out_status_ff;
endmodule

@@ design/chip8_instruction_executor_top.sv @@
// CHIP-8 executor: one opcode or memory byte load per request, one result each.
// Requests come on req_valid/req_ready with req_type selecting execute (0)
// or memory byte load (1); each transfer yields exactly one rsp_ transfer
// with PC, index, VF, timers and a status code.
// Ordinary opcodes and loads pass IDLE, DECODE and DONE; BCD store steps
// one digit per BCD state, and the register block ops step one byte per
// pass through MEMRD and BLOCK (store) or MEMRD, MEMWAIT and BLOCK (load).
// One request is executed at a time; req_ready is high only when idle.
// The result sits in an output register: while the receiver stalls, one
// more request is taken and executed, then waits until the result is
// taken; the result stays put meanwhile.
// Reset clears V registers, index, timers and stack level, sets PC to 512.
// Memory and the return stack are not cleared; read them only once written.
`include "assert_macros.svh"
module chip8_instruction_executor_top #(
   parameter int MEM_DEPTH   = c8x_pkg::MemDepthDefault,
   parameter int STACK_DEPTH = c8x_pkg::StackDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [15:0] req_opcode,
   input  logic [15:0] req_key_mask,
   input  logic [7:0]  req_random_byte,
   input  logic [11:0] req_load_addr,
   input  logic [7:0]  req_load_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_next_pc,
   output logic [15:0] rsp_index_value,
   output logic [7:0]  rsp_flag_value,
   output logic [7:0]  rsp_delay_value,
   output logic [7:0]  rsp_sound_value,
   output logic [1:0]  rsp_status
);
   import c8x_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   c8x_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .sts, .cmd
   );

   c8x_dpath #(.MEM_DEPTH(MEM_DEPTH), .STACK_DEPTH(STACK_DEPTH)) u_dpath (
      .clock, .reset, .cmd, .sts,
      .req_type, .req_opcode, .req_key_mask, .req_random_byte,
      .req_load_addr, .req_load_data,
      .rsp_next_pc, .rsp_index_value, .rsp_flag_value,
      .rsp_delay_value, .rsp_sound_value, .rsp_status
   );

   `ASSERT_IMPLY(a_ready_idle, clock, reset, req_ready, !cmd.out_load)
   `ASSERT_NEXT(a_rsp_after_load, clock, reset, cmd.out_load, rsp_valid)
   `ASSERT_IMPLY(a_no_overwrite, clock, reset, cmd.out_load && rsp_valid, rsp_ready)
endmodule

@@ bench/chip8_instruction_executor_top_test.sv @@
// Self-checking testbench for the CHIP-8 instruction executor
`timescale 1ns / 100ps
module chip8_instruction_executor_top_test;
   import c8x_pkg::*;

   localparam logic [3:0] OP_SYS = 4'h0, OP_JP = 4'h1, OP_CALL = 4'h2, OP_SE_IMM = 4'h3,
      OP_SNE_IMM = 4'h4, OP_SE_REG = 4'h5, OP_LD_IMM = 4'h6, OP_ADD_IMM = 4'h7,
      OP_ALU = 4'h8, OP_SNE_REG = 4'h9, OP_LD_I = 4'hA, OP_JP_V0 = 4'hB, OP_RND = 4'hC,
      OP_DRAW = 4'hD, OP_KEY = 4'hE, OP_MISC = 4'hF;
   localparam logic [3:0] ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3,
      ALU_ADD = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7, ALU_SHL = 4'hE,
      ALU_BAD = 4'h8;
   localparam logic [7:0] KEY_DOWN = 8'h9E, KEY_UP = 8'hA1;
   localparam logic [7:0] MISC_GET_DT = 8'h07, MISC_WAIT_KEY = 8'h0A, MISC_SET_DT = 8'h15,
      MISC_SET_ST = 8'h18, MISC_ADD_I = 8'h1E, MISC_FONT = 8'h29, MISC_BCD = 8'h33,
      MISC_STORE = 8'h55, MISC_LOAD = 8'h65;
   localparam logic [15:0] OPC_RET = 16'h00EE, OPC_CLS = 16'h00E0;
   localparam logic REQ_EXEC = 1'b0, REQ_LOAD = 1'b1;
   localparam int MEM_SIZE = MemDepthDefault;
   localparam int STACK_SIZE = StackDepthDefault;

   typedef struct packed {
      logic        kind;
      logic [15:0] opcode;
      logic [15:0] keys;
      logic [7:0]  rnd;
      logic [11:0] addr;
      logic [7:0]  data;
   } c8_req_type;

   typedef struct packed {
      logic [11:0] pc;
      logic [15:0] index;
      logic [7:0]  vf;
      logic [7:0]  delay;
      logic [7:0]  sound;
      logic [1:0]  status;
   } c8_rsp_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_type = 0;
   logic [15:0] req_opcode = 0;
   logic [15:0] req_key_mask = 0;
   logic [7:0]  req_random_byte = 0;
   logic [11:0] req_load_addr = 0;
   logic [7:0]  req_load_data = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [11:0] rsp_next_pc;
   logic [15:0] rsp_index_value;
   logic [7:0]  rsp_flag_value;
   logic [7:0]  rsp_delay_value;
   logic [7:0]  rsp_sound_value;
   logic [1:0]  rsp_status;

   chip8_instruction_executor_top i_dut (.*);

   always #10 clock = ~clock;

   // machine state mirror
   logic [7:0]  v_regs [16];
   logic [15:0] idx_reg;
   logic [11:0] pc_reg;
   logic [11:0] call_stack [STACK_SIZE];
   int          stack_ptr;
   logic [7:0]  delay_tmr, sound_tmr;
   logic [7:0]  mem_bytes [MEM_SIZE];
   bit          mem_written [MEM_SIZE];

   c8_req_type pending_reqs[$];
   c8_rsp_type expected_state[$];
   int total_reqs, sent_reqs, checked_rsps, mismatches;
   int n_over, n_under, n_unsup, n_block;
   int send_idle_pct, recv_idle_pct;
   bit req_xfer;

   function automatic logic [11:0] mem_at(logic [15:0] base, int k);
      return 12'(base + k);
   endfunction

   // advance the mirror by one request and return the resulting state
   function automatic c8_rsp_type apply_req(c8_req_type r);
      c8_rsp_type o;
      logic [1:0] st;
      logic [3:0] x, y, n;
      logic [7:0] nn, vx, vy, res, flg;
      logic [11:0] pc2, pc4;
      bit         pressed, alu_flag;
      st = ST_OK;
      if (r.kind == REQ_LOAD) begin
         mem_bytes[r.addr] = r.data;
         mem_written[r.addr] = 1;
      end else begin
         x = r.opcode[11:8]; y = r.opcode[7:4]; n = r.opcode[3:0]; nn = r.opcode[7:0];
         vx = v_regs[x]; vy = v_regs[y];
         pc2 = pc_reg + 12'd2; pc4 = pc_reg + 12'd4;
         pc_reg = pc2;
         case (r.opcode[15:12])
            OP_SYS: begin
               if (r.opcode == OPC_RET) begin
                  if (stack_ptr == 0) st = ST_UNDER;
                  else begin
                     stack_ptr--;
                     pc_reg = call_stack[stack_ptr];
                  end
               end else st = ST_UNSUP;
            end
            OP_JP: pc_reg = r.opcode[11:0];
            OP_CALL: begin
               if (stack_ptr >= STACK_SIZE) st = ST_OVER;
               else begin
                  call_stack[stack_ptr] = pc2;
                  stack_ptr++;
                  pc_reg = r.opcode[11:0];
               end
            end
            OP_SE_IMM: if (vx == nn) pc_reg = pc4;
            OP_SNE_IMM: if (vx != nn) pc_reg = pc4;
            OP_SE_REG: if (n != 0) st = ST_UNSUP; else if (vx == vy) pc_reg = pc4;
            OP_SNE_REG: if (n != 0) st = ST_UNSUP; else if (vx != vy) pc_reg = pc4;
            OP_LD_IMM: v_regs[x] = nn;
            OP_ADD_IMM: v_regs[x] = vx + nn;
            OP_ALU: begin
               alu_flag = 1;
               case (n)
                  ALU_MOV: begin v_regs[x] = vy; alu_flag = 0; end
                  ALU_OR: begin v_regs[x] = vx | vy; alu_flag = 0; end
                  ALU_AND: begin v_regs[x] = vx & vy; alu_flag = 0; end
                  ALU_XOR: begin v_regs[x] = vx ^ vy; alu_flag = 0; end
                  ALU_ADD: {flg[0], res} = {1'b0, vx} + {1'b0, vy};
                  ALU_SUB: begin res = vx - vy; flg[0] = vx >= vy; end
                  ALU_SHR: begin res = vx >> 1; flg[0] = vx[0]; end
                  ALU_SUBN: begin res = vy - vx; flg[0] = vy >= vx; end
                  ALU_SHL: begin res = vx << 1; flg[0] = vx[7]; end
                  default: begin st = ST_UNSUP; alu_flag = 0; end
               endcase
               // flag lands after the result, so VF as target keeps the flag
               if (alu_flag) begin
                  v_regs[x] = res;
                  v_regs[15] = {7'd0, flg[0]};
               end
            end
            OP_LD_I: idx_reg = {4'd0, r.opcode[11:0]};
            OP_JP_V0: pc_reg = r.opcode[11:0] + {4'd0, v_regs[0]};
            OP_RND: v_regs[x] = r.rnd & nn;
            OP_DRAW: st = ST_UNSUP;
            OP_KEY: begin
               pressed = (vx < 16) && r.keys[vx[3:0]];
               if (nn == KEY_DOWN) begin if (pressed) pc_reg = pc4; end
               else if (nn == KEY_UP) begin if (!pressed) pc_reg = pc4; end
               else st = ST_UNSUP;
            end
            default: begin
               case (nn)
                  MISC_GET_DT: v_regs[x] = delay_tmr;
                  MISC_SET_DT: delay_tmr = vx;
                  MISC_SET_ST: sound_tmr = vx;
                  MISC_ADD_I: idx_reg = idx_reg + {8'd0, vx};
                  MISC_FONT: idx_reg = 16'(vx * 5);
                  MISC_BCD: begin
                     mem_bytes[mem_at(idx_reg, 0)] = 8'(vx / 100);
                     mem_bytes[mem_at(idx_reg, 1)] = 8'((vx / 10) % 10);
                     mem_bytes[mem_at(idx_reg, 2)] = 8'(vx % 10);
                     for (int k = 0; k < 3; k++) mem_written[mem_at(idx_reg, k)] = 1;
                  end
                  MISC_STORE: for (int k = 0; k <= x; k++) begin
                     mem_bytes[mem_at(idx_reg, k)] = v_regs[k];
                     mem_written[mem_at(idx_reg, k)] = 1;
                  end
                  MISC_LOAD: for (int k = 0; k <= x; k++)
                     v_regs[k] = mem_bytes[mem_at(idx_reg, k)];
                  default: st = ST_UNSUP;
               endcase
            end
         endcase
         if (st == ST_OVER) n_over++;
         if (st == ST_UNDER) n_under++;
         if (st == ST_UNSUP) n_unsup++;
      end
      o.pc = pc_reg; o.index = idx_reg; o.vf = v_regs[15];
      o.delay = delay_tmr; o.sound = sound_tmr; o.status = st;
      return o;
   endfunction

   function automatic void queue_req(c8_req_type r);
      pending_reqs.push_back(r);
      expected_state.push_back(apply_req(r));
   endfunction

   function automatic void queue_load(logic [11:0] a, logic [7:0] d);
      c8_req_type r;
      r = {REQ_EXEC, 16'($urandom), 16'($urandom), 8'($urandom), a, d};
      r.kind = REQ_LOAD;
      queue_req(r);
   endfunction

   // block loads only read bytes already written; fill the gaps first
   function automatic void queue_exec(logic [15:0] op, logic [15:0] keys);
      c8_req_type r;
      if (op[15:12] == OP_MISC && op[7:0] == MISC_LOAD) begin
         for (int k = 0; k <= op[11:8]; k++)
            if (!mem_written[mem_at(idx_reg, k)]) queue_load(mem_at(idx_reg, k), 8'($urandom));
         n_block++;
      end
      if (op[15:12] == OP_MISC && op[7:0] == MISC_STORE) n_block++;
      r = {REQ_EXEC, op, keys, 8'($urandom), 12'($urandom), 8'($urandom)};
      queue_req(r);
   endfunction

   function automatic logic [15:0] pick_opcode();
      logic [3:0] hi, x, y;
      logic [7:0] lo;
      logic [7:0] misc_ops [9];
      logic [3:0] alu_ops [9];
      misc_ops = '{MISC_GET_DT, MISC_SET_DT, MISC_SET_ST, MISC_ADD_I, MISC_FONT,
                   MISC_BCD, MISC_STORE, MISC_LOAD, MISC_WAIT_KEY};
      alu_ops = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR,
                  ALU_SUBN, ALU_SHL};
      hi = 4'($urandom); x = 4'($urandom); y = 4'($urandom); lo = 8'($urandom);
      if ($urandom_range(9) == 0) return 16'($urandom);
      case (hi)
         OP_SYS: return ($urandom_range(3) != 0) ? OPC_RET : {OP_SYS, x, lo};
         OP_SE_REG, OP_SNE_REG: return {hi, x, y, ($urandom_range(5) == 0) ? 4'($urandom) : 4'd0};
         OP_LD_IMM, OP_SE_IMM, OP_SNE_IMM:
            return {hi, x, ($urandom_range(1) == 0) ? 8'($urandom_range(15)) : lo};
         OP_ALU: return {hi, x, y, ($urandom_range(7) == 0) ? 4'($urandom) : alu_ops[$urandom_range(8)]};
         OP_KEY: return {hi, x, ($urandom_range(7) == 0) ? lo : ($urandom_range(1) ? KEY_DOWN : KEY_UP)};
         OP_MISC: return {hi, x, ($urandom_range(7) == 0) ? lo : misc_ops[$urandom_range(8)]};
         default: return {hi, x, lo};
      endcase
   endfunction

   // driver: present the next request at the falling edge
   always @(negedge clock) begin
      c8_req_type r;
      if (sent_reqs < total_reqs / 3) begin
         send_idle_pct = 25; recv_idle_pct = 62;
      end else if (sent_reqs < 2 * total_reqs / 3) begin
         send_idle_pct = 62; recv_idle_pct = 25;
      end else begin
         send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (!reset) begin
         if (!req_valid || req_xfer) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               r = pending_reqs.pop_front();
               req_type <= r.kind; req_opcode <= r.opcode; req_key_mask <= r.keys;
               req_random_byte <= r.rnd; req_load_addr <= r.addr; req_load_data <= r.data;
               req_valid <= 1;
            end else req_valid <= 0;
         end
         rsp_ready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   // monitor: count request transfers, check each response transfer
   always @(posedge clock) begin
      c8_rsp_type got, want;
      req_xfer <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) sent_reqs++;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_next_pc, rsp_index_value, rsp_flag_value, rsp_delay_value,
                rsp_sound_value, rsp_status};
         if (expected_state.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
         end else begin
            want = expected_state.pop_front();
            checked_rsps++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d mismatch: expected %p, got %p", checked_rsps, want, got);
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      for (int k = 0; k < 16; k++) v_regs[k] = 0;
      for (int k = 0; k < MEM_SIZE; k++) begin mem_bytes[k] = 0; mem_written[k] = 0; end
      idx_reg = 0; pc_reg = PC_RESET; stack_ptr = 0; delay_tmr = 0; sound_tmr = 0;

      // directed: error cases, stack depth limits, flag edge cases
      queue_exec(OPC_RET, 16'h0000);
      queue_exec(OPC_CLS, 16'hFFFF);
      queue_exec(16'h0123, 0);
      queue_exec({OP_DRAW, 12'h123}, 0);
      queue_exec({OP_MISC, 4'h0, MISC_WAIT_KEY}, 0);
      queue_exec({OP_SE_REG, 8'h12, 4'h1}, 0);
      queue_exec({OP_ALU, 8'h12, ALU_BAD}, 0);
      queue_exec({OP_KEY, 4'h0, 8'h00}, 0);
      queue_exec({OP_MISC, 4'h0, 8'hFF}, 0);
      queue_exec({OP_LD_IMM, 4'h1, 8'hFF}, 0);
      queue_exec({OP_LD_IMM, 4'hF, 8'h01}, 0);
      queue_exec({OP_ALU, 4'hF, 4'h1, ALU_ADD}, 0);
      queue_exec({OP_ALU, 4'h2, 4'h1, ALU_SUBN}, 0);
      queue_exec({OP_LD_IMM, 4'h3, 8'hFF}, 0);
      queue_exec({OP_KEY, 4'h3, KEY_DOWN}, 16'hFFFF);
      queue_exec({OP_KEY, 4'h3, KEY_UP}, 16'hFFFF);
      queue_exec({OP_LD_I, 12'hFFF}, 0);
      queue_exec({OP_MISC, 4'h3, MISC_BCD}, 0);
      queue_exec({OP_MISC, 4'hF, MISC_STORE}, 0);
      queue_exec({OP_MISC, 4'hF, MISC_LOAD}, 0);
      queue_exec({OP_JP_V0, 12'hFFF}, 0);
      for (int k = 0; k <= STACK_SIZE; k++) queue_exec({OP_CALL, 12'($urandom)}, 0);
      queue_exec(OPC_RET, 0);

      while (pending_reqs.size() < 1000) begin
         if ($urandom_range(9) == 0) queue_load(12'($urandom), 8'($urandom));
         else queue_exec(pick_opcode(), 16'($urandom));
      end
      total_reqs = pending_reqs.size();

      repeat (6) @(posedge clock);
      reset <= 0;
      wait (sent_reqs == total_reqs);
      wait (expected_state.size() == 0);
      repeat (60) @(posedge clock);
      if (expected_state.size() != 0) mismatches++;
      $display("Checked %0d responses to %0d requests, %0d register block ops,",
               checked_rsps, total_reqs, n_block);
      $display("%0d overflows, %0d underflows, %0d unsupported; %0d mismatches",
               n_over, n_under, n_unsup, mismatches);
      if (mismatches == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

@@ files.f @@
+incdir+design
design/c8x_pkg.sv
design/c8x_ctrl.sv
design/c8x_dpath.sv
design/chip8_instruction_executor_top.sv
bench/chip8_instruction_executor_top_test.sv
